### rtl/rpr_pkg.sv
// Package for the reversed pixel row packer: types, constants and pixel-width helpers.
`timescale 1ns / 1ps
package rpr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned BPP_W  = 4;
  localparam int unsigned SLOT_W = 3;

  localparam logic [BPP_W-1:0] BPP_RESET = 4'd1;

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_EMIT
  } rpr_state_t;

  // Clamp the programmed width into the range 1..8.
  function automatic logic [BPP_W-1:0] eff_bpp(input logic [BPP_W-1:0] bpp);
    logic [BPP_W-1:0] res;
    begin
      if (bpp == 4'd0) begin
        res = 4'd1;
      end else if (bpp > 4'd8) begin
        res = 4'd8;
      end else begin
        res = bpp;
      end
      return res;
    end
  endfunction

  // Pixels per byte, 8 divided by the effective width, truncated.
  function automatic logic [BPP_W-1:0] pix_per_byte(input logic [BPP_W-1:0] bpp);
    logic [BPP_W-1:0] res;
    begin
      case (bpp)
        4'd1:    res = 4'd8;
        4'd2:    res = 4'd4;
        4'd3:    res = 4'd2;
        4'd4:    res = 4'd2;
        default: res = 4'd1;
      endcase
      return res;
    end
  endfunction

endpackage

### rtl/rpr_buf.sv
// Group buffer: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module rpr_buf
  import rpr_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/rpr_emit.sv
// Row-end read sequencer: walks the buffer downward and feeds the output register.
`timescale 1ns / 1ps
module rpr_emit
  import rpr_pkg::*;
#(
  parameter int unsigned AW = 6,
  parameter int unsigned CW = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CW-1:0]     nbytes,
  input  logic              row_ovf,
  output logic              busy,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [BYTE_W-1:0] rd_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_packed_byte,
  output logic              out_last_byte,
  output logic              out_row_overflow
);

  logic [CW-1:0]     rem_r, rem_nxt;
  logic              q_valid_r, q_valid_nxt;
  logic              q_last_r, q_last_nxt;
  logic              ovf_r, ovf_nxt;
  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r, ob_nxt;
  logic              ol_r, ol_nxt;
  logic              oo_r, oo_nxt;
  logic              move;
  logic              issue;
  logic [CW-1:0]     rem_m1;

  // The read data stage moves on when the output register is free or emptying.
  assign move   = q_valid_r && (!ov_r || !out_stall);
  assign issue  = (rem_r != '0) && (!q_valid_r || move);
  assign rem_m1 = rem_r - CW'(1);

  always_comb begin
    rem_nxt     = rem_r;
    q_valid_nxt = q_valid_r;
    q_last_nxt  = q_last_r;
    ovf_nxt     = ovf_r;
    ov_nxt      = ov_r && out_stall;
    ob_nxt      = ob_r;
    ol_nxt      = ol_r;
    oo_nxt      = oo_r;
    if (start) begin
      rem_nxt = nbytes;
      ovf_nxt = row_ovf;
    end else if (issue) begin
      rem_nxt = rem_m1;
    end
    if (issue) begin
      q_valid_nxt = 1'b1;
      q_last_nxt  = (rem_r == CW'(1));
    end else if (move) begin
      q_valid_nxt = 1'b0;
    end
    if (move) begin
      ov_nxt = 1'b1;
      ob_nxt = rd_data;
      ol_nxt = q_last_r;
      oo_nxt = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r     <= '0;
      q_valid_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      rem_r     <= rem_nxt;
      q_valid_r <= q_valid_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_last_r <= q_last_nxt;
    ovf_r    <= ovf_nxt;
    ob_r     <= ob_nxt;
    ol_r     <= ol_nxt;
    oo_r     <= oo_nxt;
  end

  assign busy             = (rem_r != '0) || q_valid_r;
  assign rd_en            = issue;
  assign rd_addr          = rem_m1[AW-1:0];
  assign out_valid        = ov_r;
  assign out_packed_byte  = ob_r;
  assign out_last_byte    = ol_r;
  assign out_row_overflow = oo_r;

endmodule

### rtl/pixel_row_packer_reversed_core.sv
// Top level of the reversed pixel row packer: pixel loading, row control and assertions.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake           Beat payload
//  in_*      input      in_valid/in_stall   in_pixel_value, in_last_in_row
//  out_*     output     out_valid/out_stall out_packed_byte, out_last_byte, out_row_overflow
//  cfg_*     input      cfg_wr_en           cfg_wr_data (bits per pixel)
//
// While a row loads, one pixel beat is accepted every cycle. Pixels of a group are
// gathered in an accumulator register, and each completed group is written once into
// the group buffer memory. A row end with complete groups stalls the input while the
// buffer is read back top down, one byte per cycle while the output does not stall.
// Reset is synchronous and active low and sets one bit per pixel; an output stall
// holds the output and read stages.
module pixel_row_packer_reversed_core
  import rpr_pkg::*;
#(
  parameter int unsigned ROW_BYTES_MAX = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_pixel_value,
  input  logic              in_last_in_row,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_packed_byte,
  output logic              out_last_byte,
  output logic              out_row_overflow,
  input  logic              cfg_wr_en,
  input  logic [BPP_W-1:0]  cfg_wr_data
);

  // Address width of the buffer and width of a group count that can hold the depth.
  localparam int unsigned AW = (ROW_BYTES_MAX > 1) ? $clog2(ROW_BYTES_MAX) : 1;
  localparam int unsigned CW = $clog2(ROW_BYTES_MAX + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(ROW_BYTES_MAX);

  rpr_state_t        state_r, state_nxt;
  logic [BPP_W-1:0]  bpp_r, bpp_nxt;
  logic [CW-1:0]     grp_r, grp_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              ovf_r, ovf_nxt;
  logic [BYTE_W-1:0] acc_r, acc_nxt;

  logic [BPP_W-1:0]  bpp;
  logic [BPP_W-1:0]  ppb;
  logic [SLOT_W-1:0] shamt;
  logic [BYTE_W-1:0] shifted;
  logic [BYTE_W-1:0] merged;
  logic              full;
  logic              in_acc;
  logic              grp_done;
  logic              row_ovf;

  logic              wr_en;
  logic              emit_start;
  logic              emit_busy;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;

  assign bpp     = eff_bpp(bpp_r);
  assign ppb     = pix_per_byte(bpp);
  // The slot index times the width never reaches eight, so three bits suffice.
  assign shamt   = SLOT_W'({1'b0, slot_r} * bpp);
  assign shifted = in_pixel_value << shamt;
  assign merged  = (slot_r == '0) ? shifted : (acc_r | shifted);
  assign full    = (grp_r == FULL_CNT);

  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign grp_done = in_acc && !full && ({1'b0, slot_r} == ppb - BPP_W'(1));
  assign wr_en    = grp_done;
  assign row_ovf  = ovf_r || (in_acc && full);

  always_comb begin
    state_nxt  = state_r;
    bpp_nxt    = bpp_r;
    grp_nxt    = grp_r;
    slot_nxt   = slot_r;
    ovf_nxt    = ovf_r;
    acc_nxt    = acc_r;
    emit_start = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else if (grp_done) begin
            grp_nxt  = grp_r + CW'(1);
            slot_nxt = '0;
          end else begin
            acc_nxt  = merged;
            slot_nxt = slot_r + SLOT_W'(1);
          end
          if (in_last_in_row) begin
            // Only complete groups go out; a partial group is dropped here.
            if (grp_nxt != '0) begin
              emit_start = 1'b1;
              state_nxt  = ST_EMIT;
            end
            grp_nxt  = '0;
            slot_nxt = '0;
            ovf_nxt  = 1'b0;
          end
        end
      end
      ST_EMIT: begin
        if (!emit_busy) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
    // A width change drops any partly loaded row.
    if (cfg_wr_en) begin
      bpp_nxt  = cfg_wr_data;
      grp_nxt  = '0;
      slot_nxt = '0;
      ovf_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      bpp_r   <= BPP_RESET;
      grp_r   <= '0;
      slot_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bpp_r   <= bpp_nxt;
      grp_r   <= grp_nxt;
      slot_r  <= slot_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  rpr_buf #(
    .DEPTH (ROW_BYTES_MAX),
    .AW    (AW)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (grp_r[AW-1:0]),
    .wr_data (merged),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rpr_emit #(
    .AW (AW),
    .CW (CW)
  ) u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (emit_start),
    .nbytes           (grp_r + CW'(grp_done)),
    .row_ovf          (row_ovf),
    .busy             (emit_busy),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_packed_byte  (out_packed_byte),
    .out_last_byte    (out_last_byte),
    .out_row_overflow (out_row_overflow)
  );

  // The group count never runs past the buffer depth.
  a_grp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    grp_r <= FULL_CNT)
    else $error("group count beyond buffer depth");

  // The slot inside a group stays below the pixels per byte.
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, slot_r} < ppb)
    else $error("pixel slot out of range");

  // The buffer is never written while a row is being read back.
  a_no_wr_emit: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_LOAD) && !emit_busy)
    else $error("buffer write during read-back");

  // A read-back is started only from an idle sequencer and keeps it busy next cycle.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit_start |-> !emit_busy ##1 emit_busy)
    else $error("read-back start overlaps a running one");

endmodule

### bench/pixel_row_packer_reversed_core_tb.sv
// Self-checking testbench for the reversed pixel row packer, with a built-in byte predictor.
`timescale 1ns / 1ps
//
// A queue of pixel beats, filled by the stimulus process, feeds a clocked driver on the
// in_* channel. On every accepted pixel beat the driver updates a private model of the
// packer: its row buffer, its stored pixel count and its overflow flag. When a beat
// closes a row, the model appends the bytes that row must produce to a queue of
// expected bytes, last group first. A clocked monitor on the out_* channel
// pops the oldest expected byte for every accepted output beat and compares each field.
// Both channels idle and stall at random, with some phases that run without gaps.
module pixel_row_packer_reversed_core_tb
  import rpr_pkg::*;
();

  localparam int ROW_BYTES_MAX = 64;
  // Longest run of cycles with no beat on either channel and no width write before the run is called hung.
  localparam int HANG_LIMIT = 2000;

  typedef struct {
    logic [BYTE_W-1:0] value;
    logic              last;
  } pixel_beat_t;

  typedef struct {
    logic [BYTE_W-1:0] packed_byte;
    logic              last_byte;
    logic              row_overflow;
  } packed_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_pixel_value = '0;
  logic              in_last_in_row = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_packed_byte;
  logic              out_last_byte;
  logic              out_row_overflow;
  logic              cfg_wr_en = 1'b0;
  logic [BPP_W-1:0]  cfg_wr_data = '0;

  pixel_row_packer_reversed_core #(
    .ROW_BYTES_MAX(ROW_BYTES_MAX)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_value   (in_pixel_value),
    .in_last_in_row   (in_last_in_row),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_packed_byte  (out_packed_byte),
    .out_last_byte    (out_last_byte),
    .out_row_overflow (out_row_overflow),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Stimulus and scoreboard state.
  pixel_beat_t    pixel_q[$];
  packed_result_t expected_bytes[$];
  int             queued_beats = 0;
  int             accepted_beats = 0;
  int             bytes_checked = 0;
  int             widths_used = 0;
  int             errors = 0;
  int             idle_cycles = 0;
  bit             no_gaps = 1'b0;

  // Private copy of the packer's state, advanced only on accepted beats and width writes.
  logic [BPP_W-1:0]  width_reg = BPP_RESET;
  logic [BYTE_W-1:0] row_buf[ROW_BYTES_MAX];
  int                stored_pixels = 0;
  bit                row_spilled = 1'b0;
  int                spilled_rows = 0;

  // Effective width is the programmed code clamped into 1..8; a byte holds 8 / width pixels.
  function automatic int pixels_per_byte(input logic [BPP_W-1:0] code);
    int w;
    w = (code == 0) ? 1 : ((code > 8) ? 8 : int'(code));
    return 8 / w;
  endfunction

  // Short gaps dominate; now and then a long one lets the other side run dry.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Fold one accepted pixel into the model; a row end queues that row's bytes.
  function automatic void absorb_pixel(input logic [BYTE_W-1:0] pix, input logic last);
    int per_byte, w, idx, slot, nbytes, k;
    logic [15:0] widened;
    packed_result_t res;
    per_byte = pixels_per_byte(width_reg);
    w = 8 / per_byte;
    if (per_byte == 2) w = (width_reg == 3) ? 3 : 4;
    if (stored_pixels < ROW_BYTES_MAX * per_byte) begin
      idx = stored_pixels / per_byte;
      slot = stored_pixels % per_byte;
      // The value is not masked to its width, so high bits spill into later slots.
      widened = {8'd0, pix} << (slot * w);
      if (slot == 0) begin
        row_buf[idx] = widened[7:0];
      end else begin
        row_buf[idx] = row_buf[idx] | widened[7:0];
      end
      stored_pixels++;
    end else begin
      // Buffer full: the pixel is dropped but its row end still counts.
      row_spilled = 1'b1;
    end
    if (last) begin
      nbytes = stored_pixels / per_byte;
      if (row_spilled) spilled_rows++;
      for (k = 0; k < nbytes; k++) begin
        res.packed_byte = row_buf[nbytes - 1 - k];
        res.last_byte = (k == nbytes - 1);
        res.row_overflow = row_spilled;
        expected_bytes.insert(expected_bytes.size(), res);
      end
      stored_pixels = 0;
      row_spilled = 1'b0;
    end
  endfunction

  task automatic queue_pixel(input logic [BYTE_W-1:0] value, input logic last);
    pixel_beat_t b;
    b.value = value;
    b.last = last;
    pixel_q.insert(pixel_q.size(), b);
    queued_beats++;
  endtask

  // A row of random pixels; an unterminated one is left for a width write to discard.
  task automatic push_row(input int len, input bit terminate);
    int i;
    for (i = 0; i < len; i++) begin
      queue_pixel(BYTE_W'($urandom_range(0, 255)), terminate && (i == len - 1));
    end
  endtask

  // Block until every queued beat is in and every expected byte is out, then let the
  // packer settle. Sampling at the falling edge avoids races with the clocked driver
  // and monitor.
  task automatic wait_idle(input int settle);
    do begin
      @(negedge clk);
    end while (!(accepted_beats == queued_beats && expected_bytes.size() == 0));
    repeat (settle) @(negedge clk);
  endtask

  // Width writes only happen with the packer idle; any partial row is thrown away.
  task automatic write_width(input logic [BPP_W-1:0] code);
    wait_idle(10);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= code;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    width_reg = code;
    stored_pixels = 0;
    row_spilled = 1'b0;
    widths_used++;
  endtask

  // Input driver: present the next queued pixel once the current beat is taken, with
  // random gaps between beats. Valid only drops when the beat has been accepted.
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_pixel(in_pixel_value, in_last_in_row);
        accepted_beats++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pixel_q.size() > 0) begin
          in_valid <= 1'b1;
          in_pixel_value <= pixel_q[0].value;
          in_last_in_row <= pixel_q[0].last;
          void'(pixel_q.pop_front());
          gap_left <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check every accepted byte against the oldest expectation, and
  // stall the output channel in random stretches.
  int stall_left = 0;

  always @(posedge clk) begin
    packed_result_t want;
    int n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        bytes_checked++;
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte: expected none, actual %02h last %0b overflow %0b",
                   $time, out_packed_byte, out_last_byte, out_row_overflow);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_packed_byte !== want.packed_byte) begin
            $display("%0t: packed_byte mismatch: expected %02h, actual %02h",
                     $time, want.packed_byte, out_packed_byte);
            errors++;
          end
          if (out_last_byte !== want.last_byte) begin
            $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                     $time, want.last_byte, out_last_byte);
            errors++;
          end
          if (out_row_overflow !== want.row_overflow) begin
            $display("%0t: row_overflow mismatch: expected %0b, actual %0b",
                     $time, want.row_overflow, out_row_overflow);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        n = pick_gap();
        out_stall <= (n > 0);
        stall_left <= (n > 0) ? n - 1 : 0;
      end
    end
  end

  // Hang detector: a long stretch without any beat or write means the packer is stuck.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= HANG_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d bytes still expected",
                 $time, HANG_LIMIT, expected_bytes.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // Stimulus: a directed opening, then phases of random rows at a range of widths.
  initial begin
    logic [BPP_W-1:0] phase_width[9];
    int p, per, row_len, phase_pixels;
    phase_width = '{4'd8, 4'd2, 4'd3, 4'd1, 4'd6, 4'd4, 4'd7, 4'd5, 4'd11};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset width of one bit: a full group of eight pixels whose unmasked values
    // overlap, including both extremes of the pixel range.
    queue_pixel(8'hFF, 1'b0);
    queue_pixel(8'h00, 1'b0);
    queue_pixel(8'h01, 1'b0);
    queue_pixel(8'h02, 1'b0);
    queue_pixel(8'h80, 1'b0);
    queue_pixel(8'h00, 1'b0);
    queue_pixel(8'h00, 1'b0);
    queue_pixel(8'h07, 1'b1);
    // A row shorter than one group produces nothing.
    queue_pixel(8'h5A, 1'b0);
    queue_pixel(8'hA5, 1'b1);
    // A row left open, then discarded by a width write.
    push_row(5, 1'b0);
    write_width(4'd4);
    // Two groups at four bits; they must come out second group first.
    queue_pixel(8'hFF, 1'b0);
    queue_pixel(8'h0F, 1'b0);
    queue_pixel(8'h00, 1'b0);
    queue_pixel(8'hF0, 1'b1);
    // A code of zero behaves as one bit per pixel: a lone pixel gives no byte.
    write_width(4'd0);
    queue_pixel(8'hC3, 1'b1);
    // Codes above eight behave as eight bits: every pixel is its own byte.
    write_width(4'd15);
    queue_pixel(8'h00, 1'b0);
    queue_pixel(8'hFF, 1'b0);
    queue_pixel(8'hAA, 1'b1);

    for (p = 0; p < 9; p++) begin
      write_width(phase_width[p]);
      no_gaps = (p % 3 == 2);
      per = pixels_per_byte(phase_width[p]);
      // At a full byte per pixel the buffer holds 64 pixels: fill it past the top,
      // which also gives the longest burst of bytes from a single row.
      if (p == 0) push_row(ROW_BYTES_MAX + $urandom_range(1, 3), 1'b1);
      phase_pixels = 0;
      while (phase_pixels < 3) begin
        if ($urandom_range(0, 7) == 0) begin
          row_len = $urandom_range(1, per);
        end else begin
          row_len = $urandom_range(per, 3 * per + 2);
        end
        push_row(row_len, 1'b1);
        phase_pixels += row_len;
      end
      if ($urandom_range(0, 1) == 1) push_row($urandom_range(1, per + 1), 1'b0);
    end

    wait_idle(40);
    if (expected_bytes.size() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
      errors++;
    end
    $display("Drove %0d pixel beats over %0d width settings and checked %0d packed bytes;",
             accepted_beats, widths_used + 1, bytes_checked);
    $display("%0d rows ran past the end of the row buffer.", spilled_rows);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
